@@ hdl/hcfd_pkg.sv @@
// shared types, constants and cipher helpers for the hopping code frame decoder
package hcfd_pkg;

    localparam int          KEY_W         = 64;
    localparam int          FRAME_W       = 64;
    localparam int          WORD_W        = 32;
    localparam int          KL_ROUNDS     = 528;
    localparam int          ENC_BYTES_DEF = 4;
    localparam logic [63:0] KEY_RESET     = 64'hABCD_EF01_2345_0002;
    localparam logic [31:0] KL_NLF        = 32'h3A5C_742E;
    localparam logic [27:0] SERIAL_ONES   = 28'hFFF_FFFF;
    localparam int          KIDX_W        = $clog2(KEY_W);
    localparam int          CNT_W         = $clog2(KL_ROUNDS);

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SER_ZERO = 3'd1,
        ST_SER_ONES = 3'd2,
        ST_REPEAT   = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    // top level sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECRYPT,
        S_RESULT
    } t_state;

    // handshake between sequencer and cipher core
    typedef struct packed {
        logic busy;
        logic done;
    } t_cph_stat;

    // one decrypt round: shift left, feed back nonlinear and key taps
    function automatic logic [WORD_W-1:0] kl_dec_round(input logic [WORD_W-1:0] x,
                                                       input logic              kb);
        logic [4:0] idx;
        logic       nb;
        idx = {x[30], x[25], x[19], x[8], x[0]};
        nb  = KL_NLF[idx] ^ x[15] ^ x[31] ^ kb;
        return {x[WORD_W-2:0], nb};
    endfunction

endpackage

@@ hdl/hcfd_cipher.sv @@
// iterative decrypt core: one round per cycle through a shared round unit
module hcfd_cipher
    import hcfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_data,
    input  logic [KEY_W-1:0]  i_key,
    output t_cph_stat         o_stat,
    output logic [WORD_W-1:0] o_result
);

    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(KL_ROUNDS - 1);
    localparam logic [KIDX_W-1:0] KIDX_START = KIDX_W'((KL_ROUNDS - 1) % KEY_W);

    logic [WORD_W-1:0] r_x;
    logic [CNT_W-1:0]  r_cnt;
    logic [KIDX_W-1:0] r_kidx;
    logic              r_busy;
    logic              r_done;

    // busy and done flags; the key bit pointer in the data path walks the key downward from index 15
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // data path: the one round unit updates the word each busy cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_data;
            r_cnt  <= '0;
            r_kidx <= KIDX_START;
        end else if (r_busy) begin
            r_x    <= kl_dec_round(r_x, i_key[r_kidx]);
            r_cnt  <= r_cnt + 1'b1;
            r_kidx <= r_kidx - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_x;

endmodule

@@ hdl/hopping_code_frame_decoder.sv @@
// top level: frame checks, repeat store, sequencer and result register
// A frame is taken when i_valid is high and o_stall low; the block then stalls its input
// until the result has been taken. A frame with an all-zeros or all-ones serial, or whose
// low ENC_BYTES bytes repeat the last stored frame, goes from the check state straight to
// the result state. Any other frame is stored for the repeat check and its hopping word
// goes through 528 decrypt rounds, one per cycle on a single round unit; the block returns
// to idle once the result is taken. The user must write the key through i_cfg_wr_en /
// i_cfg_wr_data only while no frame is in flight; the block does not enforce this.
module hopping_code_frame_decoder
    import hcfd_pkg::*;
#(
    parameter int ENC_BYTES = ENC_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [KEY_W-1:0]   i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FRAME_W-1:0] i_frame_bits,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_accepted,
    output logic [2:0]         o_status,
    output logic [WORD_W-1:0]  o_fixed_code
);

    localparam int CMP_W = ENC_BYTES * 8;

    t_state             r_state;
    t_state             n_state;
    logic [KEY_W-1:0]   r_key;
    logic [FRAME_W-1:0] r_frame;
    logic [CMP_W-1:0]   r_last;
    t_status            r_status;
    logic               r_accepted;
    logic [WORD_W-1:0]  r_fixed;
    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_start;
    logic               w_ser_zero;
    logic               w_ser_ones;
    logic               w_repeat;
    logic               w_match;
    t_cph_stat          w_cph;
    logic [WORD_W-1:0]  w_plain;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // frame checks
    assign w_ser_zero = (r_frame[59:32] == '0);
    assign w_ser_ones = (r_frame[59:32] == SERIAL_ONES);
    assign w_repeat   = (r_frame[CMP_W-1:0] == r_last);
    assign w_match    = (w_plain[23:16] == r_frame[39:32])
                     && (w_plain[31:28] == r_frame[63:60]);

    // key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_wr_en) begin
            r_key <= i_cfg_wr_data;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_ser_zero || w_ser_ones || w_repeat) n_state = S_RESULT;
                else n_state = S_DECRYPT;
            end
            S_DECRYPT: begin
                if (w_cph.done) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_acc) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        w_start = 1'b0;
        unique case (r_state)
            S_IDLE:    o_stall = 1'b0;
            S_CHECK:   w_start = !(w_ser_zero || w_ser_ones || w_repeat);
            S_DECRYPT: ;
            S_RESULT:  o_valid = 1'b1;
            default:   ;
        endcase
    end

    // repeat store, updated only when the frame goes on to decryption
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (w_start) begin
            r_last <= r_frame[CMP_W-1:0];
        end
    end

    // transaction capture and result register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_frame <= i_frame_bits;
        end
        if (r_state == S_CHECK) begin
            r_accepted <= 1'b0;
            r_fixed    <= '0;
            priority if (w_ser_zero) r_status <= ST_SER_ZERO;
            else if (w_ser_ones)     r_status <= ST_SER_ONES;
            else if (w_repeat)       r_status <= ST_REPEAT;
            else                     r_status <= ST_MISMATCH;
        end else if (r_state == S_DECRYPT && w_cph.done) begin
            r_accepted <= w_match;
            r_status   <= w_match ? ST_OK : ST_MISMATCH;
            r_fixed    <= w_match ? r_frame[FRAME_W-1:WORD_W] : '0;
        end
    end

    hcfd_cipher u_cipher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_data   (r_frame[WORD_W-1:0]),
        .i_key    (r_key),
        .o_stat   (w_cph),
        .o_result (w_plain)
    );

    assign o_accepted   = r_accepted;
    assign o_status     = r_status;
    assign o_fixed_code = r_fixed;

    // accepted flag agrees with the status code
    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted == (o_status == ST_OK)))
        else $error("accepted flag disagrees with status");

    // rejected results carry no fixed code
    a_fixed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_fixed_code == '0))
        else $error("fixed code not cleared on reject");

    // cipher finishes only while the sequencer waits for it
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cph.done |-> (r_state == S_DECRYPT))
        else $error("cipher done outside decrypt state");

    // cipher is busy throughout the decrypt phase, up to the cycle in which it signals done
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECRYPT && !w_cph.done) |-> w_cph.busy)
        else $error("cipher idle during decrypt state");

endmodule
